// ===== hdl/piecewise_linear_interpolator_top_assert.svh =====
// assertion macros used by pli_back
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_TOP_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_TOP_ASSERT_SVH

// same-cycle implication
`define PLI_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// next-cycle implication
`define PLI_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ===== hdl/pli_pkg.sv =====
// ----------------------------------------------------------------------------
// pli_pkg
// shared types, codes and defaults of the interpolator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pli_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int DATA_WIDTH_DEF  = 16;
  localparam int FRAC_BITS_DEF   = 16;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_FWD  = 2'd1;
  localparam logic [1:0] ACT_INV  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_FWD,
    OP_INV,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } q_head_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_AFTER,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS_WR,
    S_NEXT,
    S_PAIR_RD,
    S_PAIR_P,
    S_PAIR_N,
    S_DIV_INIT,
    S_DIV,
    S_MUL,
    S_FIN
  } state_t;

endpackage

// ===== hdl/pli_front.sv =====
// ----------------------------------------------------------------------------
// pli_front
// takes requests, decodes the action and queues them for the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pli_front #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   action,
  input  logic signed [DATA_WIDTH-1:0] key_in,
  input  logic signed [DATA_WIDTH-1:0] value_in,
  output pli_pkg::q_head_t             head,
  output logic signed [DATA_WIDTH-1:0] head_key,
  output logic signed [DATA_WIDTH-1:0] head_value,
  input  logic                         pop
);
  import pli_pkg::*;

  op_t                         q_op    [2];
  logic signed [DATA_WIDTH-1:0] q_key   [2];
  logic signed [DATA_WIDTH-1:0] q_value [2];
  logic                        wr_ptr;
  logic                        rd_ptr;
  logic [1:0]                  fill;
  logic                        push;
  op_t                         op_dec;

  always_comb begin
    case (action)
      ACT_LOAD: op_dec = OP_LOAD;
      ACT_FWD:  op_dec = OP_FWD;
      ACT_INV:  op_dec = OP_INV;
      default:  op_dec = OP_NOP;
    endcase
  end

  assign busy = (fill == 2'd2);
  assign push = start && !busy;

  always_ff @(posedge clk) begin
    if (push) begin
      q_op[wr_ptr]    <= op_dec;
      q_key[wr_ptr]   <= key_in;
      q_value[wr_ptr] <= value_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  assign head.valid = (fill != 2'd0);
  assign head.op    = q_op[rd_ptr];
  assign head_key   = q_key[rd_ptr];
  assign head_value = q_value[rd_ptr];

endmodule

// ===== hdl/pli_back.sv =====
// ----------------------------------------------------------------------------
// pli_back
// table search, sorted insert and interpolation with a serial divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pli_back #(
  parameter int TABLE_DEPTH = 16,
  parameter int DATA_WIDTH  = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pli_pkg::q_head_t             head,
  input  logic signed [DATA_WIDTH-1:0] head_key,
  input  logic signed [DATA_WIDTH-1:0] head_value,
  output logic                         pop,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] result_value,
  output logic [1:0]                   status
);
  import pli_pkg::*;
  `include "piecewise_linear_interpolator_top_assert.svh"

  localparam int DW  = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int DCW = $clog2(F + 1);
  localparam int PW  = DW + F + 3;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  state_t state, state_next;

  logic [2*DW-1:0] fwd_mem [TABLE_DEPTH];
  logic [2*DW-1:0] rev_mem [TABLE_DEPTH];
  logic [2*DW-1:0] fwd_rd, rev_rd, rd_data, wr_data;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic            we;

  logic            sel, is_load, drop, eq, first;
  logic signed [DW-1:0] x, partner, p, n, pv, nv;
  logic [1:0]      st;
  logic [CW-1:0]   i, lb, j, fwd_count, rev_count, cnt, pi, ni;
  logic [DW:0]     rem, dd;
  logic [DW+1:0]   trial;
  logic [F:0]      t;
  logic [DCW-1:0]  dcnt;
  logic signed [PW-1:0] prod, rnd, shr;
  logic signed [DW:0]   diff;
  logic signed [F+1:0]  tsig;
  logic signed [DW-1:0] rd_key;
  logic            q_empty;
  logic signed [DW-1:0] res_interp;
  logic                 interp_path;

  assign cnt     = sel ? rev_count : fwd_count;
  assign rd_data = sel ? rev_rd : fwd_rd;
  assign rd_key  = rd_data[2*DW-1:DW];
  assign pi      = (lb == '0) ? '0 : lb - 1'b1;
  assign ni      = (lb >= cnt) ? cnt - 1'b1 : lb;
  assign trial   = first ? {1'b0, rem} : {rem, 1'b0};
  assign diff    = {nv[DW-1], nv} - {pv[DW-1], pv};
  assign tsig    = $signed({1'b0, t});
  assign rnd     = prod + (PW'(1) <<< (F - 1));
  assign shr     = rnd >>> F;
  assign q_empty = (head.op == OP_FWD && fwd_count == '0) ||
                   (head.op == OP_INV && rev_count == '0);

  always_ff @(posedge clk) begin
    if (we && !sel) fwd_mem[wr_addr] <= wr_data;
    if (we && sel) rev_mem[wr_addr] <= wr_data;
    fwd_rd <= fwd_mem[rd_addr];
    rev_rd <= rev_mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    we         = 1'b0;
    rd_addr    = '0;
    wr_addr    = lb[AW-1:0];
    wr_data    = {x, partner};
    case (state)
      S_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          state_next = (head.op == OP_NOP || q_empty) ? S_FIN : S_START;
        end
      end
      S_START:    state_next = (cnt == '0) ? S_AFTER : S_SCAN_RD;
      S_SCAN_RD: begin
        rd_addr    = i[AW-1:0];
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (rd_key >= x || i + 1'b1 == cnt) state_next = S_AFTER;
        else state_next = S_SCAN_RD;
      end
      S_AFTER: begin
        if (!is_load) state_next = S_PAIR_RD;
        else if (eq) begin
          we = 1'b1;
          state_next = S_NEXT;
        end else if (cnt == DEPTH_C) state_next = S_NEXT;
        else if (cnt > lb) state_next = S_SHIFT_RD;
        else state_next = S_INS_WR;
      end
      S_SHIFT_RD: begin
        rd_addr    = AW'(j - 1'b1);
        state_next = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        we         = 1'b1;
        wr_addr    = j[AW-1:0];
        wr_data    = rd_data;
        state_next = (j - 1'b1 > lb) ? S_SHIFT_RD : S_INS_WR;
      end
      S_INS_WR: begin
        we         = 1'b1;
        state_next = S_NEXT;
      end
      S_NEXT:     state_next = sel ? S_FIN : S_START;
      S_PAIR_RD: begin
        rd_addr    = pi[AW-1:0];
        state_next = S_PAIR_P;
      end
      S_PAIR_P: begin
        rd_addr    = ni[AW-1:0];
        state_next = S_PAIR_N;
      end
      S_PAIR_N:   state_next = S_DIV_INIT;
      S_DIV_INIT: state_next = (n == p) ? S_MUL : S_DIV;
      S_DIV:      state_next = (dcnt == DCW'(F)) ? S_MUL : S_DIV;
      S_MUL:      state_next = S_FIN;
      S_FIN:      state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_count <= '0;
      rev_count <= '0;
      done      <= 1'b0;
    end else begin
      done <= (state == S_FIN);
      if (state == S_INS_WR) begin
        if (sel) rev_count <= rev_count + 1'b1;
        else fwd_count <= fwd_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN) begin
      result_value <= interp_path ? res_interp : '0;
      status       <= st;
    end
    case (state)
      S_IDLE: begin
        is_load <= (head.op == OP_LOAD);
        drop    <= 1'b0;
        st      <= q_empty ? ST_EMPTY : ST_OK;
        sel     <= (head.op == OP_INV);
        x       <= (head.op == OP_INV) ? head_value : head_key;
        partner <= (head.op == OP_INV) ? head_key : head_value;
      end
      S_START: begin
        i  <= '0;
        lb <= '0;
        eq <= 1'b0;
      end
      S_SCAN_CHK: begin
        if (rd_key >= x) begin
          lb <= i;
          eq <= (rd_key == x);
        end else if (i + 1'b1 == cnt) begin
          lb <= cnt;
          eq <= 1'b0;
        end else i <= i + 1'b1;
      end
      S_AFTER: begin
        j <= cnt;
        if (is_load && !eq && cnt == DEPTH_C) drop <= 1'b1;
      end
      S_SHIFT_WR: j <= j - 1'b1;
      S_NEXT: begin
        sel     <= 1'b1;
        x       <= partner;
        partner <= x;
        st      <= drop ? ST_FULL : ST_OK;
      end
      S_PAIR_P: begin
        p  <= rd_key;
        pv <= rd_data[DW-1:0];
      end
      S_PAIR_N: begin
        n  <= rd_key;
        nv <= rd_data[DW-1:0];
      end
      S_DIV_INIT: begin
        t     <= '0;
        rem   <= {x[DW-1], x} - {p[DW-1], p};
        dd    <= {n[DW-1], n} - {p[DW-1], p};
        dcnt  <= '0;
        first <= 1'b1;
      end
      S_DIV: begin
        if (trial >= {1'b0, dd}) begin
          rem <= (DW+1)'(trial - {1'b0, dd});
          t   <= {t[F-1:0], 1'b1};
        end else begin
          rem <= trial[DW:0];
          t   <= {t[F-1:0], 1'b0};
        end
        dcnt  <= dcnt + 1'b1;
        first <= 1'b0;
      end
      S_MUL: begin
        prod <= diff * tsig;
        st   <= ST_OK;
      end
      default: begin
      end
    endcase
  end

  // result of the interpolation, taken when the product is ready
  assign res_interp = pv + shr[DW-1:0];

  always_ff @(posedge clk) begin
    if (rst) interp_path <= 1'b0;
    else if (state == S_IDLE) interp_path <= 1'b0;
    else if (state == S_MUL) interp_path <= 1'b1;
  end

  `PLI_ASSERT_IMP(a_fwd_cnt, clk, rst, 1'b1, fwd_count <= DEPTH_C)
  `PLI_ASSERT_IMP(a_rev_cnt, clk, rst, 1'b1, rev_count <= DEPTH_C)
  `PLI_ASSERT_NXT(a_done_pulse, clk, rst, done, !done)
  `PLI_ASSERT_IMP(a_err_zero, clk, rst, done && status != ST_OK, result_value == '0)

endmodule

// ===== hdl/piecewise_linear_interpolator_top.sv =====
// a query scans the table, then runs the serial divider, skipped when both neighbours coincide;
// an empty table or an unused action goes straight to the result;
// a load searches, shifts and inserts in both tables in turn
// one request in the back end at a time, the next starts while the result is out
// busy rises only when the two-entry request queue is full; the receiver cannot stall
// reset (synchronous, rst high) empties both tables and the queue
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_top
// sorted breakpoint tables with forward and inverse linear interpolation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module piecewise_linear_interpolator_top #(
  parameter int TABLE_DEPTH = pli_pkg::TABLE_DEPTH_DEF,
  parameter int DATA_WIDTH  = pli_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS   = pli_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   action,
  input  logic signed [DATA_WIDTH-1:0] key_in,
  input  logic signed [DATA_WIDTH-1:0] value_in,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] result_value,
  output logic [1:0]                   status
);
  import pli_pkg::*;

  q_head_t                      head;
  logic signed [DATA_WIDTH-1:0] head_key, head_value;
  logic                         pop;

  pli_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk, .rst, .start, .busy, .action, .key_in, .value_in,
    .head, .head_key, .head_value, .pop
  );

  pli_back #(
    .TABLE_DEPTH(TABLE_DEPTH), .DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk, .rst, .head, .head_key, .head_value, .pop,
    .done, .result_value, .status
  );

endmodule
